@@ src/spnt_pkg.sv @@
// Package for the sustain pedal note tracker: command codes, fixed field widths
// and the control/status structs between controller and datapath. No dependencies.
package spnt_pkg;

    // Fixed widths of the item fields
    localparam int CMD_W  = 3;
    localparam int CHAN_W = 4;
    localparam int KEY_W  = 7;

    // Command codes (6 and 7 are unused and do nothing)
    localparam logic [CMD_W-1:0] CMD_KEY_DOWN = 3'd0;
    localparam logic [CMD_W-1:0] CMD_KEY_UP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEDAL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the input item, reset counter and answers
        logic step;     // process the channel row at the walk counter
        logic publish;  // copy the answers into the output register
    } spnt_ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic last_ch;  // walk counter sits on the last channel
    } spnt_stat_t;

endpackage

@@ src/spnt_ctrl.sv @@
// Controller of the sustain pedal note tracker: walks every channel row once per item.
// Depends on spnt_pkg.
module spnt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  spnt_pkg::spnt_stat_t stat,
    output spnt_pkg::spnt_ctrl_t ctrl
);
    import spnt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Handshake and control strobe decode
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        ctrl.load    = in_valid && in_ready;
        ctrl.step    = (state_reg == ST_WALK);
        ctrl.publish = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    end

    // Next state and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.load)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.last_ch)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (ctrl.publish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/spnt_datapath.sv @@
// Datapath of the sustain pedal note tracker: channel row storage, item capture,
// per-row update and query accumulation, output register. Depends on spnt_pkg.
module spnt_datapath #(
    parameter int NOTE_COUNT    = 128,
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spnt_pkg::spnt_ctrl_t       ctrl,
    output spnt_pkg::spnt_stat_t       stat,
    input  logic [spnt_pkg::CMD_W-1:0]  cmd,
    input  logic [spnt_pkg::CHAN_W-1:0] channel,
    input  logic                       all_channels,
    input  logic [spnt_pkg::KEY_W-1:0]  note,
    input  logic [spnt_pkg::KEY_W-1:0]  low_key,
    input  logic [spnt_pkg::KEY_W-1:0]  high_key,
    input  logic                       pedal_value,
    output logic                       retrigger,
    output logic                       stop_note,
    output logic                       note_sustaining,
    output logic                       any_playing,
    output logic                       any_sustaining,
    output logic                       any_key_held,
    output logic                       pedal_is_down
);
    import spnt_pkg::*;

    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int NOTE_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

    typedef logic [NOTE_COUNT-1:0] row_t;

    // Channel state
    row_t                     held_reg  [CHANNEL_COUNT];
    row_t                     sound_reg [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] pedal_reg;

    // Captured item
    logic [CMD_W-1:0]  cmd_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic              all_reg;
    logic [NOTE_W-1:0] nidx_reg;
    logic              note_ok_reg;
    logic              pv_reg;
    row_t              mask_reg;
    row_t              mask_next;

    logic [CH_W-1:0]   cnt_reg;

    // Answer accumulators
    logic retrig_reg, stop_reg, nsus_reg, play_reg, asus_reg, held_any_reg, ped_any_reg;
    logic retrig_next, stop_next, nsus_next, play_next, asus_next, held_any_next,
          ped_any_next;

    // Row being processed and its update
    row_t row_h, row_s, new_h, new_s;
    logic ped, new_p, hit_key, hit_sel;

    assign stat.last_ch = (cnt_reg == CH_W'(CHANNEL_COUNT - 1));

    // Key range mask, built once per item
    always_comb
    begin
        for (int i = 0; i < NOTE_COUNT; i++)
        begin
            mask_next[i] = ({1'b0, low_key} <= 8'(i)) && (8'(i) <= {1'b0, high_key});
        end
    end

    // Capture of the input item
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg     <= cmd;
            chan_reg    <= channel;
            all_reg     <= all_channels;
            nidx_reg    <= note[NOTE_W-1:0];
            note_ok_reg <= ({1'b0, note} < 8'(NOTE_COUNT));
            pv_reg      <= pedal_value;
            mask_reg    <= mask_next;
        end
    end

    // Walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.step && !stat.last_ch)
        begin
            cnt_reg <= cnt_reg + CH_W'(1);
        end
    end

    // Per-row update and answer accumulation
    always_comb
    begin
        row_h   = held_reg[cnt_reg];
        row_s   = sound_reg[cnt_reg];
        ped     = pedal_reg[cnt_reg];
        hit_key = (CHAN_W'(cnt_reg) == chan_reg);
        hit_sel = all_reg || hit_key;
        new_h   = row_h;
        new_s   = row_s;
        new_p   = ped;
        retrig_next   = retrig_reg;
        stop_next     = stop_reg;
        nsus_next     = nsus_reg;
        play_next     = play_reg;
        asus_next     = asus_reg;
        held_any_next = held_any_reg;
        ped_any_next  = ped_any_reg;
        case (cmd_reg)
            CMD_KEY_DOWN:
            begin
                if (hit_key && note_ok_reg)
                begin
                    retrig_next     = retrig_reg | (ped & row_s[nidx_reg]);
                    new_h[nidx_reg] = 1'b1;
                    new_s[nidx_reg] = 1'b1;
                end
            end
            CMD_KEY_UP:
            begin
                if (hit_key && note_ok_reg)
                begin
                    if (!ped)
                    begin
                        stop_next       = 1'b1;
                        new_s[nidx_reg] = 1'b0;
                    end
                    new_h[nidx_reg] = 1'b0;
                end
            end
            CMD_PEDAL:
            begin
                if (hit_key)
                begin
                    new_p = pv_reg;
                end
            end
            CMD_RELEASE:
            begin
                if (hit_sel)
                begin
                    new_s = row_s & row_h;
                end
            end
            CMD_CLEAR:
            begin
                if (hit_sel)
                begin
                    new_h = '0;
                    new_s = '0;
                    new_p = 1'b0;
                end
            end
            CMD_QUERY:
            begin
                if (hit_sel)
                begin
                    ped_any_next  = ped_any_reg | ped;
                    nsus_next     = nsus_reg
                                    | (note_ok_reg & row_s[nidx_reg] & ~row_h[nidx_reg]);
                    play_next     = play_reg | (|(row_s & mask_reg));
                    asus_next     = asus_reg | (|(row_s & ~row_h & mask_reg));
                    held_any_next = held_any_reg | (|(row_h & mask_reg));
                end
            end
            default:
            begin
                new_p = ped;
            end
        endcase
    end

    // Channel state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                held_reg[c]  <= '0;
                sound_reg[c] <= '0;
            end
            pedal_reg <= '0;
        end
        else if (ctrl.step)
        begin
            held_reg[cnt_reg]  <= new_h;
            sound_reg[cnt_reg] <= new_s;
            pedal_reg[cnt_reg] <= new_p;
        end
    end

    // Accumulators, cleared per item
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            retrig_reg   <= 1'b0;
            stop_reg     <= 1'b0;
            nsus_reg     <= 1'b0;
            play_reg     <= 1'b0;
            asus_reg     <= 1'b0;
            held_any_reg <= 1'b0;
            ped_any_reg  <= 1'b0;
        end
        else if (ctrl.step)
        begin
            retrig_reg   <= retrig_next;
            stop_reg     <= stop_next;
            nsus_reg     <= nsus_next;
            play_reg     <= play_next;
            asus_reg     <= asus_next;
            held_any_reg <= held_any_next;
            ped_any_reg  <= ped_any_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (ctrl.publish)
        begin
            retrigger       <= retrig_reg;
            stop_note       <= stop_reg;
            note_sustaining <= nsus_reg;
            any_playing     <= play_reg;
            any_sustaining  <= asus_reg;
            any_key_held    <= held_any_reg;
            pedal_is_down   <= ped_any_reg;
        end
    end

endmodule

@@ src/sustain_pedal_note_tracker.sv @@
// Sustain pedal note tracker, top level: controller and datapath.
// Depends on spnt_pkg, spnt_ctrl and spnt_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: key down, key up,
//   set pedal, release sustained, clear, or query. Every item gives exactly one
//   result item on the output channel (out_valid/out_ready); flags that do not
//   belong to the command read zero.
//   Each item walks all CHANNEL_COUNT channel rows, one row per cycle, through a
//   single read-modify-write unit on the row storage. The result is written to the
//   output register after the walk, and a new item is accepted only once that
//   result has been published to the output register.
//   in_ready is high while the block is idle, even if an earlier result has not
//   yet been taken; a stalled receiver holds the result in the output register,
//   and a following item then completes its walk and waits until that register
//   is free.
//   Reset clears all held keys, sounding notes and pedal flags at once; no item
//   and no result are in flight afterwards.
module sustain_pedal_note_tracker #(
    parameter int NOTE_COUNT    = 128,
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [spnt_pkg::CMD_W-1:0]  cmd,
    input  logic [spnt_pkg::CHAN_W-1:0] channel,
    input  logic                       all_channels,
    input  logic [spnt_pkg::KEY_W-1:0]  note,
    input  logic [spnt_pkg::KEY_W-1:0]  low_key,
    input  logic [spnt_pkg::KEY_W-1:0]  high_key,
    input  logic                       pedal_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       retrigger,
    output logic                       stop_note,
    output logic                       note_sustaining,
    output logic                       any_playing,
    output logic                       any_sustaining,
    output logic                       any_key_held,
    output logic                       pedal_is_down
);
    import spnt_pkg::*;

    spnt_ctrl_t ctrl;
    spnt_stat_t stat;

    // Sequencer
    spnt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Row storage and answers
    spnt_datapath #(
        .NOTE_COUNT    (NOTE_COUNT),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .cmd             (cmd),
        .channel         (channel),
        .all_channels    (all_channels),
        .note            (note),
        .low_key         (low_key),
        .high_key        (high_key),
        .pedal_value     (pedal_value),
        .retrigger       (retrigger),
        .stop_note       (stop_note),
        .note_sustaining (note_sustaining),
        .any_playing     (any_playing),
        .any_sustaining  (any_sustaining),
        .any_key_held    (any_key_held),
        .pedal_is_down   (pedal_is_down)
    );

endmodule

@@ src/spnt_checker.sv @@
// Port-level checks for the sustain pedal note tracker, bound to the top level.
// No package needed; the bind at the end attaches it to every top-level instance.
module spnt_port_checks (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       retrigger,
    input logic                       stop_note,
    input logic                       note_sustaining,
    input logic                       any_playing,
    input logic                       any_sustaining,
    input logic                       any_key_held,
    input logic                       pedal_is_down
);

    logic query_any;
    assign query_any = note_sustaining || any_playing || any_sustaining || any_key_held
                       || pedal_is_down;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(retrigger) && $stable(stop_note)
            && $stable(query_any))
        else $error("result changed while stalled");

    // Busy for the row walk once an item is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while walk in progress");

    // A new result appears only at the end of a walk
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a completed walk");

    // Key flags and query flags never mix
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(retrigger && stop_note) && !((retrigger || stop_note) && query_any))
        else $error("flags of different commands set together");

    // Sustained in range implies sounding in range
    a_sus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && any_sustaining |-> any_playing)
        else $error("sustaining without playing");

endmodule

bind sustain_pedal_note_tracker spnt_port_checks u_chk (.*);

@@ verif/spnt_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the sustain pedal note tracker: keeps its own copy of the
// per-channel held keys, sounding notes and pedal flags, predicts the answer to
// every accepted item and compares each output item. Depends on spnt_pkg.
module spnt_checker #(
    parameter int NOTE_COUNT    = 128,
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [spnt_pkg::CMD_W-1:0]  cmd,
    input  logic [spnt_pkg::CHAN_W-1:0] channel,
    input  logic                        all_channels,
    input  logic [spnt_pkg::KEY_W-1:0]  note,
    input  logic [spnt_pkg::KEY_W-1:0]  low_key,
    input  logic [spnt_pkg::KEY_W-1:0]  high_key,
    input  logic                        pedal_value,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        retrigger,
    input  logic                        stop_note,
    input  logic                        note_sustaining,
    input  logic                        any_playing,
    input  logic                        any_sustaining,
    input  logic                        any_key_held,
    input  logic                        pedal_is_down,
    output int                          mismatch_count,
    output int                          pending_count,
    output int                          answers_checked
);
    import spnt_pkg::*;

    typedef struct packed {
        logic retrigger;
        logic stop_note;
        logic note_sustaining;
        logic any_playing;
        logic any_sustaining;
        logic any_key_held;
        logic pedal_is_down;
    } answer_t;

    // Mirrored tracker state
    logic [NOTE_COUNT-1:0]    held_map  [CHANNEL_COUNT];
    logic [NOTE_COUNT-1:0]    sound_map [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] pedal_down;

    // Answers still owed by the block, oldest first
    answer_t answers_due [$];
    answer_t want_answer;
    answer_t seen_answer;

    // Apply one command item to the mirrored state and work out its answer
    function automatic answer_t track_event(
        input logic [CMD_W-1:0]  c_cmd,
        input logic [CHAN_W-1:0] c_ch,
        input logic              c_all,
        input logic [KEY_W-1:0]  c_note,
        input logic [KEY_W-1:0]  c_lo,
        input logic [KEY_W-1:0]  c_hi,
        input logic              c_pv
    );
        answer_t               ans;
        logic                  ch_ok;
        logic                  note_ok;
        int                    top_key;
        logic [NOTE_COUNT-1:0] range_mask;
        ans     = '0;
        ch_ok   = int'(c_ch) < CHANNEL_COUNT;
        note_ok = int'(c_note) < NOTE_COUNT;
        case (c_cmd)
            CMD_KEY_DOWN:
            begin
                if (ch_ok && note_ok)
                begin
                    // retrigger only when the pedal kept the note sounding
                    ans.retrigger = pedal_down[c_ch] && sound_map[c_ch][c_note];
                    held_map[c_ch][c_note]  = 1'b1;
                    sound_map[c_ch][c_note] = 1'b1;
                end
            end
            CMD_KEY_UP:
            begin
                if (ch_ok && note_ok)
                begin
                    if (!pedal_down[c_ch])
                    begin
                        ans.stop_note           = 1'b1;
                        sound_map[c_ch][c_note] = 1'b0;
                    end
                    held_map[c_ch][c_note] = 1'b0;
                end
            end
            CMD_PEDAL:
            begin
                if (ch_ok)
                    pedal_down[c_ch] = c_pv;
            end
            CMD_RELEASE:
            begin
                // sustained notes fall silent: only held keys keep sounding
                for (int c = 0; c < CHANNEL_COUNT; c++)
                    if (c_all || (ch_ok && c == int'(c_ch)))
                        sound_map[c] &= held_map[c];
            end
            CMD_CLEAR:
            begin
                for (int c = 0; c < CHANNEL_COUNT; c++)
                begin
                    if (c_all || (ch_ok && c == int'(c_ch)))
                    begin
                        held_map[c]   = '0;
                        sound_map[c]  = '0;
                        pedal_down[c] = 1'b0;
                    end
                end
            end
            CMD_QUERY:
            begin
                // high key clamps to the top note; low above high leaves an empty mask
                top_key = (int'(c_hi) > NOTE_COUNT - 1) ? NOTE_COUNT - 1 : int'(c_hi);
                for (int n = 0; n < NOTE_COUNT; n++)
                    range_mask[n] = (n >= int'(c_lo)) && (n <= top_key);
                for (int c = 0; c < CHANNEL_COUNT; c++)
                begin
                    if (c_all || c == int'(c_ch))
                    begin
                        if (pedal_down[c])
                            ans.pedal_is_down = 1'b1;
                        if (note_ok && sound_map[c][c_note] && !held_map[c][c_note])
                            ans.note_sustaining = 1'b1;
                        if (|(sound_map[c] & range_mask))
                            ans.any_playing = 1'b1;
                        if (|(sound_map[c] & ~held_map[c] & range_mask))
                            ans.any_sustaining = 1'b1;
                        if (|(held_map[c] & range_mask))
                            ans.any_key_held = 1'b1;
                    end
                end
            end
            default:
            begin
                // spare codes: no change, all-zero answer
            end
        endcase
        return ans;
    endfunction

    task automatic check_field(input string field_name, input logic want, input logic seen);
        if (seen !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] answer %0d: %s expected %b, got %b",
                         $time, answers_checked, field_name, want, seen);
        end
    endtask

    // Watch both channels; output side first so an answer meets its own item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                held_map[c]  = '0;
                sound_map[c] = '0;
            end
            pedal_down      = '0;
            answers_due.delete();
            mismatch_count  = 0;
            pending_count   = 0;
            answers_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] answer item with no command outstanding", $time);
                end
                else
                begin
                    want_answer = answers_due.pop_front();
                    seen_answer = {retrigger, stop_note, note_sustaining, any_playing,
                                   any_sustaining, any_key_held, pedal_is_down};
                    check_field("retrigger", want_answer.retrigger, seen_answer.retrigger);
                    check_field("stop_note", want_answer.stop_note, seen_answer.stop_note);
                    check_field("note_sustaining", want_answer.note_sustaining,
                                seen_answer.note_sustaining);
                    check_field("any_playing", want_answer.any_playing,
                                seen_answer.any_playing);
                    check_field("any_sustaining", want_answer.any_sustaining,
                                seen_answer.any_sustaining);
                    check_field("any_key_held", want_answer.any_key_held,
                                seen_answer.any_key_held);
                    check_field("pedal_is_down", want_answer.pedal_is_down,
                                seen_answer.pedal_is_down);
                end
                answers_checked++;
            end
            if (in_valid && in_ready)
                answers_due.push_back(track_event(cmd, channel, all_channels, note,
                                                  low_key, high_key, pedal_value));
            pending_count = answers_due.size();
        end
    end

endmodule

@@ verif/tb_sustain_pedal_note_tracker.sv @@
`timescale 1ns / 100ps
// Testbench top for the sustain pedal note tracker: clock, reset, command
// stimulus, output back-pressure and verdict. Depends on spnt_pkg, the block
// and spnt_checker.
module tb_sustain_pedal_note_tracker;
    import spnt_pkg::*;

    localparam int TRACK_NOTES    = 128;
    localparam int TRACK_CHANNELS = 16;

    // Spare command codes, decoded as no-ops by the block
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int PHASE_ITEMS  = 250;
    localparam int SQUEEZE_ITEMS = 25;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 2000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [CMD_W-1:0]  cmd          = CMD_QUERY;
    logic [CHAN_W-1:0] channel      = '0;
    logic              all_channels = 1'b0;
    logic [KEY_W-1:0]  note         = '0;
    logic [KEY_W-1:0]  low_key      = '0;
    logic [KEY_W-1:0]  high_key     = '0;
    logic              pedal_value  = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic              retrigger;
    logic              stop_note;
    logic              note_sustaining;
    logic              any_playing;
    logic              any_sustaining;
    logic              any_key_held;
    logic              pedal_is_down;

    int mismatch_count;
    int pending_count;
    int answers_checked;

    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    logic hold_req        = 1'b0;
    int   quiet_cycles    = 0;
    int   cmd_hits [8]    = '{default: 0};

    sustain_pedal_note_tracker #(
        .NOTE_COUNT   (TRACK_NOTES),
        .CHANNEL_COUNT(TRACK_CHANNELS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .channel        (channel),
        .all_channels   (all_channels),
        .note           (note),
        .low_key        (low_key),
        .high_key       (high_key),
        .pedal_value    (pedal_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .retrigger      (retrigger),
        .stop_note      (stop_note),
        .note_sustaining(note_sustaining),
        .any_playing    (any_playing),
        .any_sustaining (any_sustaining),
        .any_key_held   (any_key_held),
        .pedal_is_down  (pedal_is_down)
    );

    spnt_checker #(
        .NOTE_COUNT   (TRACK_NOTES),
        .CHANNEL_COUNT(TRACK_CHANNELS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .channel        (channel),
        .all_channels   (all_channels),
        .note           (note),
        .low_key        (low_key),
        .high_key       (high_key),
        .pedal_value    (pedal_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .retrigger      (retrigger),
        .stop_note      (stop_note),
        .note_sustaining(note_sustaining),
        .any_playing    (any_playing),
        .any_sustaining (any_sustaining),
        .any_key_held   (any_key_held),
        .pedal_is_down  (pedal_is_down),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .answers_checked(answers_checked)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles, %0d answers outstanding",
                     quiet_cycles, pending_count);
            $display("** sustain_pedal_note_tracker: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one command item, after random idle cycles, and wait for acceptance
    task automatic send_item(
        input logic [CMD_W-1:0]  i_cmd,
        input logic [CHAN_W-1:0] i_ch,
        input logic              i_all,
        input logic [KEY_W-1:0]  i_note,
        input logic [KEY_W-1:0]  i_lo,
        input logic [KEY_W-1:0]  i_hi,
        input logic              i_pv
    );
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= i_cmd;
        channel      <= i_ch;
        all_channels <= i_all;
        note         <= i_note;
        low_key      <= i_lo;
        high_key     <= i_hi;
        pedal_value  <= i_pv;
        do
            @(posedge clk);
        while (!in_ready);
        cmd_hits[i_cmd]++;
    endtask

    // Random command, weighted towards key traffic on a few channels and notes
    task automatic send_random();
        logic [CMD_W-1:0]  r_cmd;
        logic [CHAN_W-1:0] r_ch;
        logic [KEY_W-1:0]  r_note;
        logic [KEY_W-1:0]  r_lo;
        logic [KEY_W-1:0]  r_hi;
        int                roll;
        roll = $urandom_range(99);
        if (roll < 30)
            r_cmd = CMD_KEY_DOWN;
        else if (roll < 55)
            r_cmd = CMD_KEY_UP;
        else if (roll < 65)
            r_cmd = CMD_PEDAL;
        else if (roll < 70)
            r_cmd = CMD_RELEASE;
        else if (roll < 72)
            r_cmd = CMD_CLEAR;
        else if (roll < 97)
            r_cmd = CMD_QUERY;
        else if (roll < 99)
            r_cmd = CMD_SPARE_LO;
        else
            r_cmd = CMD_SPARE_HI;
        if ($urandom_range(99) < 60)
            r_ch = CHAN_W'($urandom_range(3));
        else
            r_ch = CHAN_W'($urandom);
        if ($urandom_range(99) < 60)
            r_note = KEY_W'($urandom_range(67, 60));
        else
            r_note = KEY_W'($urandom);
        // narrow ranges around the busy notes, or anything at all
        if ($urandom_range(99) < 60)
        begin
            r_lo = KEY_W'($urandom_range(68, 55));
            r_hi = KEY_W'($urandom_range(72, 58));
        end
        else
        begin
            r_lo = KEY_W'($urandom);
            r_hi = KEY_W'($urandom);
        end
        send_item(r_cmd, r_ch, ($urandom_range(99) < 25), r_note, r_lo, r_hi,
                  1'($urandom));
    endtask

    task automatic set_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
    endtask

    // Hand-picked sequences: extremes, every command, pedal and range corner cases
    task automatic run_directed();
        send_item(CMD_QUERY,    4'd0,  1'b1, 7'd0,   7'd0,   7'd127, 1'b0);
        send_item(CMD_KEY_DOWN, 4'd0,  1'b0, 7'd0,   7'd0,   7'd0,   1'b0);
        send_item(CMD_KEY_DOWN, 4'd15, 1'b0, 7'd127, 7'd0,   7'd0,   1'b0);
        send_item(CMD_PEDAL,    4'd15, 1'b0, 7'd0,   7'd0,   7'd0,   1'b1);
        // same key again under the pedal: retrigger
        send_item(CMD_KEY_DOWN, 4'd15, 1'b0, 7'd127, 7'd0,   7'd0,   1'b0);
        // release under the pedal: note keeps sounding, no stop
        send_item(CMD_KEY_UP,   4'd15, 1'b0, 7'd127, 7'd0,   7'd0,   1'b0);
        send_item(CMD_QUERY,    4'd15, 1'b0, 7'd127, 7'd127, 7'd127, 1'b0);
        send_item(CMD_QUERY,    4'd3,  1'b0, 7'd127, 7'd0,   7'd127, 1'b0);
        send_item(CMD_QUERY,    4'd3,  1'b1, 7'd127, 7'd0,   7'd127, 1'b0);
        // low above high: empty range
        send_item(CMD_QUERY,    4'd15, 1'b0, 7'd0,   7'd100, 7'd5,   1'b0);
        send_item(CMD_KEY_UP,   4'd0,  1'b0, 7'd0,   7'd0,   7'd0,   1'b0);
        send_item(CMD_KEY_UP,   4'd0,  1'b0, 7'd0,   7'd0,   7'd0,   1'b0);
        send_item(CMD_KEY_DOWN, 4'd7,  1'b0, 7'd64,  7'd0,   7'd0,   1'b0);
        send_item(CMD_PEDAL,    4'd7,  1'b0, 7'd0,   7'd0,   7'd0,   1'b1);
        send_item(CMD_KEY_UP,   4'd7,  1'b0, 7'd64,  7'd0,   7'd0,   1'b0);
        send_item(CMD_RELEASE,  4'd7,  1'b0, 7'd0,   7'd0,   7'd0,   1'b0);
        send_item(CMD_QUERY,    4'd7,  1'b0, 7'd64,  7'd0,   7'd127, 1'b0);
        send_item(CMD_RELEASE,  4'd0,  1'b1, 7'd0,   7'd0,   7'd0,   1'b0);
        send_item(CMD_QUERY,    4'd0,  1'b1, 7'd127, 7'd0,   7'd127, 1'b0);
        // pedal still down but note silent: no retrigger
        send_item(CMD_KEY_DOWN, 4'd15, 1'b0, 7'd127, 7'd0,   7'd0,   1'b0);
        send_item(CMD_CLEAR,    4'd15, 1'b0, 7'd0,   7'd0,   7'd0,   1'b0);
        send_item(CMD_QUERY,    4'd0,  1'b1, 7'd0,   7'd0,   7'd127, 1'b0);
        send_item(CMD_PEDAL,    4'd2,  1'b0, 7'd0,   7'd0,   7'd0,   1'b1);
        send_item(CMD_CLEAR,    4'd0,  1'b1, 7'd0,   7'd0,   7'd0,   1'b0);
        send_item(CMD_QUERY,    4'd2,  1'b1, 7'd0,   7'd0,   7'd127, 1'b0);
        send_item(CMD_SPARE_LO, 4'd5,  1'b0, 7'd60,  7'd0,   7'd127, 1'b1);
        send_item(CMD_SPARE_HI, 4'd15, 1'b1, 7'd127, 7'd127, 7'd127, 1'b1);
    endtask

    // Main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_phase(0, 0);
        run_directed();
        repeat (PHASE_ITEMS) send_random();
        set_phase(57, 0);
        repeat (PHASE_ITEMS) send_random();
        set_phase(0, 57);
        repeat (PHASE_ITEMS) send_random();
        set_phase(31, 31);
        repeat (PHASE_ITEMS) send_random();
        // receiver holds off while items keep coming, so the input backs up
        set_phase(0, 0);
        hold_req <= 1'b1;
        repeat (SQUEEZE_ITEMS) send_random();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run: %0d answers checked; key down %0d, key up %0d, pedal %0d, release %0d,",
                 answers_checked, cmd_hits[CMD_KEY_DOWN], cmd_hits[CMD_KEY_UP],
                 cmd_hits[CMD_PEDAL], cmd_hits[CMD_RELEASE]);
        $display("  clear %0d, query %0d, spare %0d; idling none/sender/receiver/both, hold-off.",
                 cmd_hits[CMD_CLEAR], cmd_hits[CMD_QUERY],
                 cmd_hits[CMD_SPARE_LO] + cmd_hits[CMD_SPARE_HI]);
        if (mismatch_count == 0 && pending_count == 0)
            $display("** sustain_pedal_note_tracker: PASSED **");
        else
            $display("** sustain_pedal_note_tracker: FAILED **");
        $finish;
    end

endmodule
